>>> src/usr_pkg.sv
// Shared constants and register codes for the ultrasonic ranger controller.
`timescale 1ns / 1ps

package usr_pkg;

  // Default parameter values
  localparam int COUNT_BITS_DEF      = 16;
  localparam int BAR_PIXELS_DEF      = 80;
  localparam int MAX_DISTANCE_MM_DEF = 1000;

  // Echo microseconds per centimetre of range
  localparam int US_PER_CM = 58;

  // Configuration register map
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 20;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_TRIGGER_PERIOD = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TRIGGER_WIDTH  = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_NEAR_LIMIT_MM  = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FAR_LIMIT_MM   = CFG_INDEX_BITS'(3);

  // Register widths
  localparam int PERIOD_BITS = 20;
  localparam int PULSE_BITS  = 8;
  localparam int LIMIT_BITS  = 10;
  localparam int LIMIT58_BITS = 16;

  // Register reset values
  localparam logic [PERIOD_BITS-1:0]  TRIGGER_PERIOD_RST = PERIOD_BITS'(100000);
  localparam logic [PULSE_BITS-1:0]   TRIGGER_WIDTH_RST  = PULSE_BITS'(10);
  localparam logic [LIMIT58_BITS-1:0] NEAR58_RST         = LIMIT58_BITS'(100 * US_PER_CM);
  localparam logic [LIMIT58_BITS-1:0] FAR58_RST          = LIMIT58_BITS'(500 * US_PER_CM);

  // Output field widths
  localparam int DIST_BITS = 10;
  localparam int BAR_BITS  = 7;
  localparam int ZONE_BITS = 2;
  localparam int DISP_BITS = 11;

  localparam logic [ZONE_BITS-1:0] ZONE_NEAR = ZONE_BITS'(0);
  localparam logic [ZONE_BITS-1:0] ZONE_MID  = ZONE_BITS'(1);
  localparam logic [ZONE_BITS-1:0] ZONE_FAR  = ZONE_BITS'(2);

  // Stream widths
  localparam int IN_DATA_BITS  = 8;
  localparam int OUT_DATA_BITS = 32;
  localparam int OUT_USER_BITS = 1;

endpackage

>>> src/ultrasonic_ranger_controller_core.sv
// Ultrasonic ranger controller: trigger timing, echo width capture and range readout.
`timescale 1ns / 1ps

// Channel      Dir  Beat content (low bit first)
// ------------ ---- -------------------------------------------------------------
// s_axis       in   tdata: echo_level, one beat per microsecond tick
// m_axis       out  tdata: trigger_out, reading_valid, range_mm, bar_len,
//                   zone, display_value; tuser: display_in_cm; one beat per tick
// cfg          in   cfg_index selects the register, cfg_data carries its value
//
// One beat enters and one leaves per clock when neither side stalls; a reading
// reaches m_axis from the accepted tick through the clamp stage and the
// reciprocal-multiply stage into the output register.
// A synchronous reset restores the register defaults and clears the counters,
// the latched width and every stage valid; other payload registers are left as
// they are. s_axis_tready and cfg_ready stay low while rst is high.
// Ready runs back combinationally through the three stages: once every stage
// holds a beat, a stall on m_axis drops s_axis_tready in the same cycle; only
// empty stages take further beats before that.

module ultrasonic_ranger_controller_core
  import usr_pkg::*;
#(
  parameter int COUNT_BITS      = COUNT_BITS_DEF,
  parameter int BAR_PIXELS      = BAR_PIXELS_DEF,
  parameter int MAX_DISTANCE_MM = MAX_DISTANCE_MM_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // Tick input
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [IN_DATA_BITS-1:0]   s_axis_tdata,   // [0] echo_level, rest zero
  // Readings
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [OUT_DATA_BITS-1:0]  m_axis_tdata,   // [0] trigger_out, [1] reading_valid,
                                                    // [11:2] range_mm, [18:12] bar_len,
                                                    // [20:19] zone, [31:21] display_value
  output logic [OUT_USER_BITS-1:0]  m_axis_tuser,   // [0] display_in_cm
  // Configuration writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  // Full-scale range in 1/58 mm units, and the reciprocal constants that turn
  // each divide into one multiply with an exact floor over the operand range.
  localparam int CAP      = MAX_DISTANCE_MM * US_PER_CM;
  localparam int CAP_BITS = $clog2(CAP + 1);

  localparam int DIST_K      = CAP_BITS + 6;
  localparam int DIST_M_BITS = CAP_BITS + 1;
  localparam int DIST_PW     = CAP_BITS + DIST_M_BITS + DIST_BITS;
  localparam longint unsigned DIST_M =
    ((64'd1 << DIST_K) + US_PER_CM - 1) / US_PER_CM;

  localparam int CM_K      = COUNT_BITS + 6;
  localparam int CM_M_BITS = COUNT_BITS + 1;
  localparam int CM_PW     = COUNT_BITS + CM_M_BITS + DISP_BITS;
  localparam longint unsigned CM_M =
    ((64'd1 << CM_K) + US_PER_CM - 1) / US_PER_CM;

  localparam int BAR_K      = 2 * CAP_BITS;
  localparam int BAR_M_BITS = CAP_BITS + 9;
  localparam int BAR_PW     = CAP_BITS + BAR_M_BITS + BAR_BITS;
  localparam longint unsigned BAR_M =
    ((longint'(BAR_PIXELS) << BAR_K) + CAP - 1) / CAP;

  // Configuration registers; limits are kept pre-scaled by 58
  logic [PERIOD_BITS-1:0]  trigger_period;
  logic [PULSE_BITS-1:0]   trigger_width;
  logic [LIMIT58_BITS-1:0] near58;
  logic [LIMIT58_BITS-1:0] far58;

  // Tick state
  logic [PERIOD_BITS-1:0] period_count;
  logic [PULSE_BITS-1:0]  pulse_count;
  logic [COUNT_BITS-1:0]  echo_count;
  logic                   echo_previous;
  logic [COUNT_BITS-1:0]  latched_width;

  // Stage valids and handshake
  logic s1_valid, s2_valid, out_valid;
  logic s2_ready, out_ready;
  logic accept;

  // Stage 1 payload (latched_width is its width field)
  logic s1_trig, s1_read;

  // Stage 2 payload
  logic                   s2_trig, s2_read;
  logic [CAP_BITS-1:0]    s2_c;
  logic [COUNT_BITS-1:0]  s2_width;
  logic [ZONE_BITS-1:0]   s2_zone;
  logic                   s2_in_cm;

  // Output register fields
  logic                  out_trig, out_read, out_in_cm;
  logic [DIST_BITS-1:0]  out_dist;
  logic [BAR_BITS-1:0]   out_bar;
  logic [ZONE_BITS-1:0]  out_zone;
  logic [DISP_BITS-1:0]  out_disp;

  // Tick logic
  logic                   echo_level;
  logic [PULSE_BITS-1:0]  pulse_load;
  logic                   trig_now;
  logic [PULSE_BITS-1:0]  pulse_count_next;
  logic [PERIOD_BITS:0]   period_inc;
  logic [PERIOD_BITS-1:0] period_count_next;
  logic [COUNT_BITS-1:0]  echo_inc;
  logic                   rise, fall;

  // Stage 1 -> 2 logic
  logic [COUNT_BITS+3:0]  width_x10;
  logic [CAP_BITS-1:0]    c_next;
  logic [ZONE_BITS-1:0]   zone_next;
  logic                   near_hit, far_hit;

  // Stage 2 -> output logic
  logic [DIST_PW-1:0] dist_prod;
  logic [CM_PW-1:0]   cm_prod;
  logic [BAR_PW-1:0]  bar_prod;
  logic [DIST_BITS-1:0] dist_q;
  logic [DISP_BITS-1:0] cm_q;

  // Ready ripples back from the output: a stage can load when it is empty or
  // its contents move on in the same cycle.
  assign out_ready     = !out_valid || m_axis_tready;
  assign s2_ready      = !s2_valid || out_ready;
  assign s_axis_tready = !rst && (!s1_valid || s2_ready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = !rst;

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_period <= TRIGGER_PERIOD_RST;
      trigger_width  <= TRIGGER_WIDTH_RST;
      near58         <= NEAR58_RST;
      far58          <= FAR58_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TRIGGER_PERIOD: trigger_period <= cfg_data[PERIOD_BITS-1:0];
        CFG_TRIGGER_WIDTH:  trigger_width  <= cfg_data[PULSE_BITS-1:0];
        CFG_NEAR_LIMIT_MM:  near58 <= LIMIT58_BITS'(cfg_data[LIMIT_BITS-1:0] * US_PER_CM);
        CFG_FAR_LIMIT_MM:   far58  <= LIMIT58_BITS'(cfg_data[LIMIT_BITS-1:0] * US_PER_CM);
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Trigger generation: reload the pulse at the start of each period, hold
  // the pin high while the pulse count is non-zero.
  assign echo_level        = s_axis_tdata[0];
  assign pulse_load        = (period_count == '0) ? trigger_width : pulse_count;
  assign trig_now          = (pulse_load != '0);
  assign pulse_count_next  = trig_now ? pulse_load - PULSE_BITS'(1) : '0;
  assign period_inc        = {1'b0, period_count} + (PERIOD_BITS+1)'(1);
  assign period_count_next = (period_inc >= {1'b0, trigger_period}) ? '0
                                                                    : period_inc[PERIOD_BITS-1:0];

  // Echo timing: edges are ignored while the trigger is driven.
  assign echo_inc = echo_count + COUNT_BITS'(1);
  assign rise     = !trig_now && !echo_previous && echo_level;
  assign fall     = !trig_now && echo_previous && !echo_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_count  <= '0;
      pulse_count   <= '0;
      echo_count    <= '0;
      echo_previous <= 1'b0;
      latched_width <= '0;
      s1_valid      <= 1'b0;
    end else begin
      if (accept) begin
        period_count  <= period_count_next;
        pulse_count   <= pulse_count_next;
        echo_count    <= rise ? '0 : echo_inc;
        echo_previous <= echo_level;
        if (fall) begin
          latched_width <= echo_inc;
        end
        s1_valid <= 1'b1;
      end else if (s2_ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_trig <= trig_now;
      s1_read <= fall;
    end
  end

  // Stage 1: clamp the width to full scale in 1/58 mm units and classify it.
  assign width_x10 = ((COUNT_BITS+4)'(latched_width) << 3) +
                     ((COUNT_BITS+4)'(latched_width) << 1);
  assign c_next    = (32'(width_x10) < 32'(CAP)) ? CAP_BITS'(width_x10) : CAP_BITS'(CAP);
  assign near_hit  = (32'(c_next) <= 32'(near58));
  assign far_hit   = (32'(c_next) <= 32'(far58));

  always_comb begin
    priority if (near_hit) begin
      zone_next = ZONE_NEAR;
    end else if (far_hit) begin
      zone_next = ZONE_MID;
    end else begin
      zone_next = ZONE_FAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_trig  <= s1_trig;
      s2_read  <= s1_read;
      s2_c     <= c_next;
      s2_width <= latched_width;
      s2_zone  <= zone_next;
      s2_in_cm <= !near_hit;
    end
  end

  // Stage 2: reciprocal multiplies give distance, whole cm and bar height.
  assign dist_prod = DIST_PW'(s2_c) * DIST_PW'(DIST_M);
  assign cm_prod   = CM_PW'(s2_width) * CM_PW'(CM_M);
  assign bar_prod  = BAR_PW'(s2_c) * BAR_PW'(BAR_M);
  assign dist_q    = dist_prod[DIST_K +: DIST_BITS];
  assign cm_q      = cm_prod[CM_K +: DISP_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s2_valid) begin
      out_trig  <= s2_trig;
      out_read  <= s2_read;
      out_dist  <= dist_q;
      out_bar   <= bar_prod[BAR_K +: BAR_BITS];
      out_zone  <= s2_zone;
      out_disp  <= s2_in_cm ? cm_q : DISP_BITS'(dist_q);
      out_in_cm <= s2_in_cm;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_disp, out_zone, out_bar, out_dist, out_read, out_trig};
  assign m_axis_tuser  = out_in_cm;

  // A reading is only taken with the trigger released.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("reading latched while trigger driven");

  // Centimetre display goes with every zone beyond near.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tdata[20:19] != ZONE_NEAR)))
    else $error("display unit disagrees with zone");

  // A period start with a non-zero width drives the trigger on that tick.
  assert property (@(posedge clk) disable iff (rst)
    (accept && period_count == '0 && trigger_width != '0) |=> (s1_valid && s1_trig))
    else $error("trigger missing at period start");

  // A falling edge outside the trigger captures the running count.
  assert property (@(posedge clk) disable iff (rst)
    (accept && fall) |=> (latched_width == $past(echo_inc) && s1_read))
    else $error("echo width not captured");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the ultrasonic ranger controller core: stream stimulus and scoreboard.

module tb;
  import usr_pkg::*;

  // Run limit in clock cycles, set to cover every beat meeting the longest gap
  // and the longest stall.
  localparam int LIMIT_CYCLES = 400_000;

  // Bit positions of the reading fields in m_axis_tdata
  localparam int DIST_LSB = 2;
  localparam int BAR_LSB  = DIST_LSB + DIST_BITS;
  localparam int ZONE_LSB = BAR_LSB + BAR_BITS;
  localparam int DISP_LSB = ZONE_LSB + ZONE_BITS;

  localparam int unsigned MM_PER_CM = 10;
  localparam int unsigned CLAMP58   = MAX_DISTANCE_MM_DEF * US_PER_CM;

  localparam int RANDOM_PHASES    = 10;
  localparam int PULSES_PER_PHASE = 4;
  localparam int NOISE_TICKS      = 40;
  localparam int REPORT_LIMIT     = 10;

  typedef struct packed {
    logic                 trig;
    logic                 fresh;
    logic [DIST_BITS-1:0] dist_mm;
    logic [BAR_BITS-1:0]  bar;
    logic [ZONE_BITS-1:0] zone;
    logic [DISP_BITS-1:0] shown;
    logic                 in_cm;
  } reading_t;

  // Scoreboard: keeps its own copy of the registers and counters, predicts the
  // reading for every accepted tick and checks readings in order.
  class ranger_scoreboard;
    bit [PERIOD_BITS-1:0]    period;
    bit [PULSE_BITS-1:0]     pulse_len;
    bit [LIMIT_BITS-1:0]     near_mm;
    bit [LIMIT_BITS-1:0]     far_mm;
    bit [PERIOD_BITS-1:0]    period_cnt;
    bit [PULSE_BITS-1:0]     pulse_left;
    bit [COUNT_BITS_DEF-1:0] echo_cnt;
    bit [COUNT_BITS_DEF-1:0] echo_width;
    bit                      echo_prev;
    reading_t                pending_readings[$];
    int                      mismatches;
    int                      ticks;
    int                      fresh_seen;
    int                      zone_seen[3];

    function new();
      period    = TRIGGER_PERIOD_RST;
      pulse_len = TRIGGER_WIDTH_RST;
      near_mm   = LIMIT_BITS'(NEAR58_RST / US_PER_CM);
      far_mm    = LIMIT_BITS'(FAR58_RST / US_PER_CM);
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [CFG_DATA_BITS-1:0] data);
      case (index)
        CFG_TRIGGER_PERIOD: period    = data[PERIOD_BITS-1:0];
        CFG_TRIGGER_WIDTH:  pulse_len = data[PULSE_BITS-1:0];
        CFG_NEAR_LIMIT_MM:  near_mm   = data[LIMIT_BITS-1:0];
        CFG_FAR_LIMIT_MM:   far_mm    = data[LIMIT_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void note_tick(logic level);
      reading_t    r;
      int unsigned c;
      int unsigned near58;
      int unsigned far58;
      // trigger: load on period wrap, drive while nonzero, count down
      if (period_cnt == 0) pulse_left = pulse_len;
      r.trig = (pulse_left != 0);
      if (r.trig) pulse_left--;
      if (32'(period_cnt) + 1 >= 32'(period)) period_cnt = '0;
      else period_cnt++;
      // echo width capture, edges dropped while the trigger is high
      echo_cnt++;
      r.fresh = 1'b0;
      if (!r.trig) begin
        if (!echo_prev && level) begin
          echo_cnt = '0;
        end else if (echo_prev && !level) begin
          echo_width = echo_cnt;
          r.fresh    = 1'b1;
        end
      end
      echo_prev = level;
      // readout, exact multiples of 1/58 mm
      c = 32'(echo_width) * MM_PER_CM;
      if (c > CLAMP58) c = CLAMP58;
      near58    = 32'(near_mm) * US_PER_CM;
      far58     = 32'(far_mm) * US_PER_CM;
      r.dist_mm = DIST_BITS'(c / US_PER_CM);
      r.bar     = BAR_BITS'(c * BAR_PIXELS_DEF / CLAMP58);
      if (c <= near58) r.zone = ZONE_NEAR;
      else if (c <= far58) r.zone = ZONE_MID;
      else r.zone = ZONE_FAR;
      r.in_cm = (c > near58);
      r.shown = r.in_cm ? DISP_BITS'(32'(echo_width) / US_PER_CM) : DISP_BITS'(r.dist_mm);
      pending_readings.push_back(r);
      ticks++;
    endfunction

    function string show(reading_t r);
      return $sformatf("trig %0b fresh %0b dist %0d bar %0d zone %0d shown %0d cm %0b",
                       r.trig, r.fresh, r.dist_mm, r.bar, r.zone, r.shown, r.in_cm);
    endfunction

    function void check_beat(logic [OUT_DATA_BITS-1:0] data, logic [OUT_USER_BITS-1:0] user);
      reading_t got;
      reading_t want;
      got.trig    = data[0];
      got.fresh   = data[1];
      got.dist_mm = data[DIST_LSB +: DIST_BITS];
      got.bar     = data[BAR_LSB +: BAR_BITS];
      got.zone    = data[ZONE_LSB +: ZONE_BITS];
      got.shown   = data[DISP_LSB +: DISP_BITS];
      got.in_cm   = user[0];
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected reading beat: %s", show(got));
        return;
      end
      want = pending_readings.pop_front();
      if (want.fresh) begin
        fresh_seen++;
        zone_seen[want.zone]++;
      end
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("reading %0d mismatch, expected: %s", ticks - pending_readings.size(),
                   show(want));
          $display("                      actual:   %s", show(got));
        end
      end
    endfunction

    function int pending();
      return pending_readings.size();
    endfunction
  endclass

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #2 clk = ~clk;

  // Block ports; the inputs are driven to known values from time zero
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_DATA_BITS-1:0]   s_axis_tdata  = '0;   // [0] echo_level
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0]  m_axis_tdata;         // trigger_out, reading_valid, range_mm,
                                                   // bar_len, zone, display_value
  logic [OUT_USER_BITS-1:0]  m_axis_tuser;         // [0] display_in_cm
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  ultrasonic_ranger_controller_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  ranger_scoreboard sb;
  int cycles     = 0;
  int settings   = 0;
  int idle_mode  = 0;   // 0: tick every cycle while ready, 1: light gaps, 2: heavy gaps
  int stall_pct  = 0;   // chance per cycle that the reading side starts a stall
  int stall_left = 0;

  // Reading side back-pressure: mostly short stalls, now and then a long one.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      m_axis_tready <= 1'b0;
      stall_left    <= ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: sample every handshake at the edge that completes it, and hold the
  // run to its cycle limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d readings outstanding", cycles, sb.pending());
      $display("FAILED: results differ");
      $finish;
    end
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready) sb.note_tick(s_axis_tdata[0]);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    case (idle_mode)
      1: begin
        if (r < 15) return $urandom_range(1, 3);
        if (r < 17) return $urandom_range(8, 40);
      end
      2: begin
        if (r < 40) return $urandom_range(1, 3);
        if (r < 45) return $urandom_range(8, 60);
      end
      default: ;
    endcase
    return 0;
  endfunction

  // Echo high time in ticks: half of them short, the rest longer.
  function automatic int echo_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(1, 10);
    if (r < 85) return $urandom_range(11, 30);
    return $urandom_range(31, 60);
  endfunction

  // Fill the bits above a register's width with junk half of the time.
  function automatic logic [CFG_DATA_BITS-1:0] pad(int unsigned value, int bits);
    logic [CFG_DATA_BITS-1:0] junk;
    junk = $urandom_range(0, 1) ? CFG_DATA_BITS'($urandom) : '0;
    return (junk << bits) | CFG_DATA_BITS'(value);
  endfunction

  // Drive one tick beat; tvalid is left high so back-to-back beats need no drop.
  task automatic send_tick(input logic level);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_BITS'(level);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic echo_pulse(input int low_ticks, input int high_ticks);
    repeat (low_ticks) send_tick(1'b0);
    repeat (high_ticks) send_tick(1'b1);
  endtask

  // Hold the sender, let every outstanding reading drain, then let the clock run on idle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // cfg_valid stays high across consecutive writes; end_writes drops it.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic set_regs(input int unsigned period, input int unsigned width,
                          input int unsigned near, input int unsigned far);
    write_reg(CFG_TRIGGER_PERIOD, CFG_DATA_BITS'(period));
    write_reg(CFG_TRIGGER_WIDTH, pad(width, PULSE_BITS));
    write_reg(CFG_NEAR_LIMIT_MM, pad(near, LIMIT_BITS));
    write_reg(CFG_FAR_LIMIT_MM, pad(far, LIMIT_BITS));
  endtask

  // Directed ticks under the reset settings. The trigger is high for the first
  // ten ticks, so the early edges are dropped; the first fall after it latches
  // the count run on from reset, then widths of three and one.
  logic directed_levels[19] = '{1, 1, 0, 1, 0, 0, 1, 1, 1, 1,
                               0, 0, 1, 1, 1, 0, 1, 0, 0};
  // Either side of the near limit (5 mm) and of the far limit (10 mm).
  int boundary_spans[6] = '{28, 29, 30, 57, 58, 59};

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    settings = 1;

    foreach (directed_levels[i]) send_tick(directed_levels[i]);
    drain();

    // Zone boundaries with the trigger switched off (zero width).
    stall_pct = 5;
    set_regs(100, 0, 5, 10);
    end_writes();
    foreach (boundary_spans[i]) echo_pulse(5, boundary_spans[i]);
    send_tick(1'b0);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_regs(100, 1, 0, 1000);
        1: set_regs(0, 255, 100, 500);          // period zero: trigger held high
        2: set_regs(1, 7, 500, 100);            // period one, far below near
        3: set_regs(1048575, 255, 1000, 0);     // longest period, far below near
        4: begin
          // period cut below the running count; limits past the clamp
          set_regs(100, 3, 1023, 1023);
          for (int k = 1; k <= 12; k++)
            write_reg(CFG_INDEX_BITS'(CFG_FAR_LIMIT_MM + k), CFG_DATA_BITS'($urandom));
        end
        5: set_regs(300, 255, 50, 800);         // widest pulse, still short of the period
        default: set_regs($urandom_range(100, 400), $urandom_range(1, 20),
                          $urandom_range(0, 8), $urandom_range(0, 12));
      endcase
      end_writes();
      idle_mode = p % 3;
      stall_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 10 : 40);

      if (p == 1 || p == 2) begin
        // trigger never drops here, so readings cannot latch: noise only
        repeat (NOISE_TICKS) send_tick(1'($urandom));
      end else begin
        for (int n = 0; n < PULSES_PER_PHASE; n++) begin
          int r;
          r = $urandom_range(0, 99);
          if (r < 3) drain();
          if (r < 80) echo_pulse($urandom_range(1, 10), echo_span());
          else repeat ($urandom_range(1, 20)) send_tick(1'($urandom));
        end
        send_tick(1'b0);
        send_tick(1'b0);
      end
      drain();
    end

    repeat (8) @(posedge clk);
    $display("Run covered %0d ticks over %0d register settings, %0d echo readings",
             sb.ticks, settings, sb.fresh_seen);
    $display("Readings by zone: near %0d, middle %0d, far %0d; %0d mismatches",
             sb.zone_seen[0], sb.zone_seen[1], sb.zone_seen[2], sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
